// ----- hw/rtl/lkv_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
// Used by lkv_ctrl, lkv_datapath and lru_key_value_cache_top; no dependencies.

package lkv_pkg;

  localparam int unsigned DefaultMaxEntries = 16;
  localparam int unsigned LimitW            = 5;
  localparam int unsigned KeyW              = 32;
  localparam int unsigned DataW             = 32;
  localparam logic [LimitW-1:0] LimitReset  = LimitW'(16);

  typedef enum logic {
    OpGet = 1'b0,
    OpPut = 1'b1
  } lkv_op_e;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StMatch  = 3'b010,
    StUpdate = 3'b100
  } lkv_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic match;
    logic update;
  } lkv_cmd_t;

endpackage

// ----- hw/rtl/lru_key_value_cache_top.sv -----
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg, lkv_ctrl and lkv_datapath.
//
// Usage:
//   Command channel: a word (operation_i, lookup_key_i, store_value_i) is taken
//   at a rising edge where start_i is high and busy_o is low. operation_i low
//   is a get, high is a put.
//   Result channel: done_o is high for one cycle with found_o, read_value_o,
//   evicted_o and evicted_key_o. Results cannot be held off; the receiver must
//   take them in that cycle.
//   The match state registers the lookup results and the update state
//   registers the result; busy_o is high only in the match cycle, in which
//   the key is compared against every entry and the victim and free slot
//   are picked. The following cycle writes back recency ranks and may take
//   the next word at the same time.
//   Configuration: cfg_we_i writes cfg_wdata_i to the entry limit (0 acts as
//   1, values above MaxEntries act as MaxEntries). Write only while idle.
//   Reset: all entries are emptied, the limit returns to 16 and the block is
//   ready as soon as reset is released.

module lru_key_value_cache_top import lkv_pkg::*; #(
  parameter int unsigned MaxEntries = DefaultMaxEntries
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     operation_i,
  input  logic signed [KeyW-1:0]   lookup_key_i,
  input  logic signed [DataW-1:0]  store_value_i,
  output logic                     done_o,
  output logic                     found_o,
  output logic signed [DataW-1:0]  read_value_o,
  output logic                     evicted_o,
  output logic signed [KeyW-1:0]   evicted_key_o,
  input  logic                     cfg_we_i,
  input  logic [LimitW-1:0]        cfg_wdata_i
);

  lkv_cmd_t cmd;

  lkv_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  lkv_datapath #(
    .MaxEntries (MaxEntries)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (operation_i),
    .lookup_key_i  (lookup_key_i),
    .store_value_i (store_value_i),
    .done_o        (done_o),
    .found_o       (found_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o)
  );

endmodule

// ----- hw/rtl/lkv_ctrl.sv -----
// Sequencer for the LRU cache: accept, match, update.
// Depends on lkv_pkg for the state and command types.

module lkv_ctrl import lkv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output lkv_cmd_t cmd_o
);

  lkv_state_e state_q, state_d;
  logic       accept;

  assign busy_o = (state_q == StMatch);
  assign accept = start_i && !busy_o;

  always_comb begin
    cmd_o.capture = accept;
    cmd_o.match   = (state_q == StMatch);
    cmd_o.update  = (state_q == StUpdate);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) state_d = StMatch;
      end
      StMatch: begin
        state_d = StUpdate;
      end
      StUpdate: begin
        // overlap the next word's capture with this word's write-back
        state_d = accept ? StMatch : StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/lkv_datapath.sv -----
// Entry store, key match, victim and free-slot selection, recency update.
// Depends on lkv_pkg; driven by the command struct from lkv_ctrl.

module lkv_datapath import lkv_pkg::*; #(
  parameter int unsigned MaxEntries = DefaultMaxEntries
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lkv_cmd_t                 cmd_i,
  input  logic                     cfg_we_i,
  input  logic [LimitW-1:0]        cfg_wdata_i,
  input  logic                     operation_i,
  input  logic signed [KeyW-1:0]   lookup_key_i,
  input  logic signed [DataW-1:0]  store_value_i,
  output logic                     done_o,
  output logic                     found_o,
  output logic signed [DataW-1:0]  read_value_o,
  output logic                     evicted_o,
  output logic signed [KeyW-1:0]   evicted_key_o
);

  localparam int unsigned AgeW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned CmpW = (CntW > LimitW) ? CntW : LimitW;

  // captured word
  lkv_op_e          op_q;
  logic [KeyW-1:0]  key_q;
  logic [DataW-1:0] val_q;

  logic [LimitW-1:0] limit_q;

  // entry store
  logic [MaxEntries-1:0] valid_q, valid_d;
  logic [KeyW-1:0]       ent_key_q  [MaxEntries];
  logic [KeyW-1:0]       ent_key_d  [MaxEntries];
  logic [DataW-1:0]      ent_data_q [MaxEntries];
  logic [DataW-1:0]      ent_data_d [MaxEntries];
  logic [AgeW-1:0]       ent_age_q  [MaxEntries];
  logic [AgeW-1:0]       ent_age_d  [MaxEntries];
  logic [CntW-1:0]       count_q, count_d;

  // match stage results
  logic [MaxEntries-1:0] hit_q, victim_q, slot_q;
  logic                  hit_any_q, evict_q, slot_any_q;
  logic [AgeW-1:0]       hit_age_q;
  logic [DataW-1:0]      rdata_q;
  logic [KeyW-1:0]       evkey_q;

  // match stage logic
  logic [MaxEntries-1:0] match_vec, hit_vec, victim_vec, free_vec, slot_vec;
  logic [AgeW-1:0]       hit_age;
  logic [DataW-1:0]      rdata_sel;
  logic [KeyW-1:0]       evkey_sel;
  logic [CmpW-1:0]       eff_limit;
  logic                  evict;

  // result words
  logic                  done_q, found_q, evicted_q;
  logic [DataW-1:0]      read_value_q;
  logic [KeyW-1:0]       evicted_key_q;

  always_comb begin
    match_vec  = '0;
    victim_vec = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      match_vec[i]  = valid_q[i] && (ent_key_q[i] == key_q);
      // the least recent entry holds the rank count-1
      victim_vec[i] = valid_q[i] && (CntW'(ent_age_q[i]) == (count_q - CntW'(1)));
    end
    hit_vec = match_vec & (~match_vec + MaxEntries'(1));

    if (limit_q == '0) begin
      eff_limit = CmpW'(1);
    end else if (CmpW'(limit_q) > CmpW'(MaxEntries)) begin
      eff_limit = CmpW'(MaxEntries);
    end else begin
      eff_limit = CmpW'(limit_q);
    end

    evict = (op_q == OpPut) && !(|match_vec) && (CmpW'(count_q) >= eff_limit) &&
            (count_q != '0) && (|victim_vec);

    free_vec = ~valid_q | (evict ? victim_vec : '0);
    slot_vec = free_vec & (~free_vec + MaxEntries'(1));

    hit_age   = '0;
    rdata_sel = '0;
    evkey_sel = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      hit_age   = hit_age   | ({AgeW{hit_vec[i]}}     & ent_age_q[i]);
      rdata_sel = rdata_sel | ({DataW{hit_vec[i]}}    & ent_data_q[i]);
      evkey_sel = evkey_sel | ({KeyW{victim_vec[i]}}  & ent_key_q[i]);
    end
  end

  // update stage logic
  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < MaxEntries; i++) begin
      ent_key_d[i]  = ent_key_q[i];
      ent_data_d[i] = ent_data_q[i];
      ent_age_d[i]  = ent_age_q[i];
      if (hit_any_q) begin
        // promote the hit entry; those younger than it age by one
        if (valid_q[i] && (ent_age_q[i] < hit_age_q)) begin
          ent_age_d[i] = ent_age_q[i] + AgeW'(1);
        end
        if (hit_q[i]) begin
          ent_age_d[i] = '0;
          if (op_q == OpPut) ent_data_d[i] = val_q;
        end
      end else if (op_q == OpPut) begin
        if (evict_q && victim_q[i]) begin
          valid_d[i]    = 1'b0;
          ent_key_d[i]  = '0;
          ent_data_d[i] = '0;
          ent_age_d[i]  = '0;
        end
        if (slot_any_q) begin
          if (valid_q[i] && !(evict_q && victim_q[i])) begin
            ent_age_d[i] = ent_age_q[i] + AgeW'(1);
          end
          if (slot_q[i]) begin
            valid_d[i]    = 1'b1;
            ent_key_d[i]  = key_q;
            ent_data_d[i] = val_q;
            ent_age_d[i]  = '0;
          end
        end
      end
    end

    count_d = count_q;
    if (!hit_any_q && (op_q == OpPut)) begin
      count_d = count_q - CntW'(evict_q) + CntW'(slot_any_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
      valid_q <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < MaxEntries; i++) begin
        ent_age_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      done_q <= cmd_i.update;
      if (cmd_i.update) begin
        valid_q <= valid_d;
        count_q <= count_d;
        for (int i = 0; i < MaxEntries; i++) begin
          ent_age_q[i] <= ent_age_d[i];
        end
      end
    end
  end

  // payload registers: invalid entries are never looked at
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= lkv_op_e'(operation_i);
      key_q <= lookup_key_i;
      val_q <= store_value_i;
    end
    if (cmd_i.match) begin
      hit_q      <= hit_vec;
      hit_any_q  <= |match_vec;
      hit_age_q  <= hit_age;
      rdata_q    <= rdata_sel;
      evict_q    <= evict;
      victim_q   <= victim_vec;
      evkey_q    <= evkey_sel;
      slot_q     <= slot_vec;
      slot_any_q <= |free_vec;
    end
    if (cmd_i.update) begin
      for (int i = 0; i < MaxEntries; i++) begin
        ent_key_q[i]  <= ent_key_d[i];
        ent_data_q[i] <= ent_data_d[i];
      end
      found_q       <= hit_any_q;
      read_value_q  <= (hit_any_q && (op_q == OpGet)) ? rdata_q : '0;
      evicted_q     <= evict_q;
      evicted_key_q <= evict_q ? evkey_q : '0;
    end
  end

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign read_value_o  = read_value_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evicted_key_q;

endmodule
